/* rtl/tpl_pkg.sv */
// Package for the table-driven logarithm: widths, constants and ROM tables.
`timescale 1ns / 1ps
package tpl_pkg;

  localparam int MANT_BITS     = 52;
  localparam int EXP_BITS      = 11;
  localparam int TABLE_BITS    = 8;
  localparam int OUT_FRAC_BITS = 52;
  localparam int ROM_DEPTH     = 1 << TABLE_BITS;
  localparam int REM_BITS      = MANT_BITS - TABLE_BITS;
  localparam int EXP_BIAS      = (1 << (EXP_BITS - 1)) - 1;

  localparam logic [63:0] LN2_Q64    = 64'hB17217F7D1CF79AC;
  localparam logic [63:0] LN2_Q62    = 64'h2C5C85FDF473DE6B;
  localparam logic [63:0] LOG10E_Q64 = 64'h6F2DEC549B9438CB;
  localparam logic [63:0] RES_MIN    = 64'h8000000000000000;
  localparam logic [63:0] ONE_Q62    = 64'h4000000000000000;

  // Series coefficients, Q62, even terms negated
  localparam logic [63:0] K8 = 64'd0 - ((ONE_Q62 + 64'd4) / 64'd8);
  localparam logic [63:0] K6 = 64'd0 - ((ONE_Q62 + 64'd3) / 64'd6);
  localparam logic [63:0] K4 = 64'd0 - ((ONE_Q62 + 64'd2) / 64'd4);
  localparam logic [63:0] K2 = 64'd0 - ((ONE_Q62 + 64'd1) / 64'd2);
  localparam logic [63:0] K7 = (ONE_Q62 + 64'd3) / 64'd7;
  localparam logic [63:0] K5 = (ONE_Q62 + 64'd2) / 64'd5;
  localparam logic [63:0] K3 = (ONE_Q62 + 64'd1) / 64'd3;
  localparam logic [63:0] K1 = ONE_Q62;

  // Last-bin correction of x
  localparam logic [63:0] LAST_CORR = 64'd1 << (61 - TABLE_BITS);

  typedef logic [ROM_DEPTH-1:0][63:0] rom_t;

  // Restoring long division, returns {remainder, quotient}
  function automatic logic [127:0] udiv(input logic [127:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return {rem[63:0], q};
  endfunction

  // ln(1+n/2^T) as 2*atanh(u), term by term
  function automatic rom_t build_log_rom();
    rom_t tab;
    logic [63:0] den, u, u2, pw, sum, k;
    logic [127:0] p, qr;
    for (int n = 0; n < ROM_DEPTH - 1; n++) begin
      den = 64'(2 * ROM_DEPTH + n);
      qr  = udiv(128'(n) << 63, den);
      u   = qr[63:0];
      p   = 128'(u) * 128'(u);
      u2  = p[126:63];
      pw  = u;
      sum = '0;
      k   = 64'd1;
      for (int j = 0; j < 400; j++) begin
        if (pw != 64'd0 && k < 64'd400) begin
          qr  = udiv(128'(pw), k);
          sum = sum + qr[63:0];
          p   = 128'(pw) * 128'(u2);
          pw  = p[126:63];
          k   = k + 64'd2;
        end
      end
      tab[n] = sum;
    end
    tab[ROM_DEPTH-1] = LN2_Q62;
    return tab;
  endfunction

  // Rounded reciprocals 2^T/(2^T+n), Q62
  function automatic rom_t build_recip_rom();
    rom_t tab;
    logic [127:0] qr;
    logic [63:0] den, q;
    for (int n = 0; n < ROM_DEPTH - 1; n++) begin
      den = 64'(ROM_DEPTH + n);
      qr  = udiv(128'(ROM_DEPTH) << 62, den);
      q   = qr[63:0];
      if ({qr[127:64], 1'b0} >= {1'b0, den}) q = q + 64'd1;
      tab[n] = q;
    end
    tab[ROM_DEPTH-1] = 64'd1 << 61;
    return tab;
  endfunction

  localparam rom_t LOG_ROM   = build_log_rom();
  localparam rom_t RECIP_ROM = build_recip_rom();

  // Per-item side data carried down the pipeline
  typedef struct packed {
    logic                special;
    logic                last;
    logic                eneg;
    logic [EXP_BITS-1:0] ae;
    logic [63:0]         logv;
  } side_t;

endpackage

/* rtl/tpl_umul.sv */
// Two-stage unsigned 64x64 multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module tpl_umul
  import tpl_pkg::*;
(
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic [127:0]  p_o
);

  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] p_q;

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
      lh_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
      hl_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      hh_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
    end
  end

  // combine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {hh_q, 64'd0} + (128'(lh_q) << 32) + (128'(hl_q) << 32) + 128'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/tpl_fmul.sv */
// Four-stage signed Q62 multiply-add: sign-magnitude product plus an addend.
`timescale 1ns / 1ps
module tpl_fmul
  import tpl_pkg::*;
(
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  input  logic [63:0]  c_i,
  output logic [63:0]  p_o
);

  logic        neg1_q, neg2_q, neg3_q;
  logic [63:0] ma_q, mb_q, c1_q, c2_q, c3_q, m_q, p_q;
  logic [63:0] ll_q, lh_q, hl_q, hh_q;
  logic [127:0] full;

  // magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[63] ^ b_i[63];
      ma_q   <= a_i[63] ? 64'd0 - a_i : a_i;
      mb_q   <= b_i[63] ? 64'd0 - b_i : b_i;
      c1_q   <= c_i;
    end
  end

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= 64'(ma_q[31:0])  * 64'(mb_q[31:0]);
      lh_q   <= 64'(ma_q[31:0])  * 64'(mb_q[63:32]);
      hl_q   <= 64'(ma_q[63:32]) * 64'(mb_q[31:0]);
      hh_q   <= 64'(ma_q[63:32]) * 64'(mb_q[63:32]);
      neg2_q <= neg1_q;
      c2_q   <= c1_q;
    end
  end

  assign full = {hh_q, 64'd0} + (128'(lh_q) << 32) + (128'(hl_q) << 32) + 128'(ll_q);

  // truncated Q62 magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= full[125:62];
      neg3_q <= neg2_q;
      c3_q   <= c2_q;
    end
  end

  // apply sign and add
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg3_q ? c3_q - m_q : c3_q + m_q;
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/table_polynomial_natural_log.sv */
// Top level: pipelined table and series logarithm of a binary64 pattern.
//
//  channel | signals                                   | direction
//  input   | in_valid_i, in_ready_o, x_bits_i          | in
//  output  | out_valid_o, out_ready_i, log_value_o,    | out
//          | status_o                                  |
//  config  | psel, penable, pwrite, paddr, pwdata,     | APB, base_mode at 0
//          | prdata, pready                            |
//
// One item per cycle while the output register is free or being taken; each item
// passes the reciprocal and square products and then the chain of four dependent
// series multiply-adds (four stages each) on its way to the output register.
// The pipeline advances as one: it holds whenever the output register is
// full and not taken. Reset clears the valid bits and base_mode.
`timescale 1ns / 1ps
module table_polynomial_natural_log
  import tpl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [63:0]  x_bits_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [63:0]  log_value_o,
  output logic         status_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int LAST = 31;
  localparam int RND_SH = 64 - OUT_FRAC_BITS;

  logic adv;
  logic base_mode_q;

  logic [LAST:1] vld_q;
  side_t         sd_q [1:LAST];
  logic          out_vld_q, out_status_q;
  logic [63:0]   out_value_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, base_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      base_mode_q <= pwdata[0];
    end
  end

  // global advance
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // decode of the operand
  logic [MANT_BITS-1:0]  mant;
  logic [EXP_BITS-1:0]   ef;
  logic                  sgn, is_nan;
  logic [TABLE_BITS-1:0] n_idx;
  side_t                 sd_d;

  always_comb begin
    mant   = x_bits_i[MANT_BITS-1:0];
    ef     = x_bits_i[MANT_BITS +: EXP_BITS];
    sgn    = x_bits_i[MANT_BITS + EXP_BITS];
    n_idx  = mant[MANT_BITS-1 -: TABLE_BITS];
    is_nan = (ef == {EXP_BITS{1'b1}}) && (mant != '0);
    sd_d.special = ((mant == '0) && (ef == '0)) || (sgn && !is_nan);
    sd_d.last    = (n_idx == {TABLE_BITS{1'b1}});
    sd_d.eneg    = (ef < EXP_BITS'(EXP_BIAS));
    sd_d.ae      = sd_d.eneg ? EXP_BITS'(EXP_BIAS) - ef : ef - EXP_BITS'(EXP_BIAS);
    sd_d.logv    = LOG_ROM[n_idx];
  end

  // valid bits and side data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[1] <= sd_d;
      for (int k = 2; k <= LAST; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // stage 1: remainder bits and reciprocal
  logic [REM_BITS-1:0] r_q;
  logic [63:0]         recip_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q     <= mant[REM_BITS-1:0];
      recip_q <= RECIP_ROM[n_idx];
    end
  end

  // stages 2-3: r * recip
  logic [127:0] px_w;
  tpl_umul u_mul_x (
    .clk_i(clk_i), .en_i(adv), .a_i(64'(r_q)), .b_i(recip_q), .p_o(px_w)
  );

  // stage 4: x, delayed up to stage 20
  logic [63:0] x_d;
  logic [63:0] x_q [4:20];
  assign x_d = px_w[MANT_BITS +: 64] - (sd_q[3].last ? LAST_CORR : 64'd0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[4] <= x_d;
      for (int k = 5; k <= 20; k++) x_q[k] <= x_q[k-1];
    end
  end

  // stages 5-8: x squared
  logic [63:0] xq_w;
  logic [63:0] xq_q [9:20];
  tpl_fmul u_sq (
    .clk_i(clk_i), .en_i(adv), .a_i(x_q[4]), .b_i(x_q[4]), .c_i(64'd0), .p_o(xq_w)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xq_q[9] <= xq_w;
      for (int k = 10; k <= 20; k++) xq_q[k] <= xq_q[k-1];
    end
  end

  // stages 9-24: even and odd series in x^2
  logic [63:0] ev1_w, ev2_w, ev3_w, ev4_w, od1_w, od2_w, od3_w, od4_w;

  tpl_fmul u_ev1 (.clk_i(clk_i), .en_i(adv), .a_i(K8), .b_i(xq_w), .c_i(K6), .p_o(ev1_w));
  tpl_fmul u_od1 (.clk_i(clk_i), .en_i(adv), .a_i(K7), .b_i(xq_w), .c_i(K5), .p_o(od1_w));
  tpl_fmul u_ev2 (.clk_i(clk_i), .en_i(adv), .a_i(ev1_w), .b_i(xq_q[12]), .c_i(K4),
                  .p_o(ev2_w));
  tpl_fmul u_od2 (.clk_i(clk_i), .en_i(adv), .a_i(od1_w), .b_i(xq_q[12]), .c_i(K3),
                  .p_o(od2_w));
  tpl_fmul u_ev3 (.clk_i(clk_i), .en_i(adv), .a_i(ev2_w), .b_i(xq_q[16]), .c_i(K2),
                  .p_o(ev3_w));
  tpl_fmul u_od3 (.clk_i(clk_i), .en_i(adv), .a_i(od2_w), .b_i(xq_q[16]), .c_i(K1),
                  .p_o(od3_w));
  tpl_fmul u_ev4 (.clk_i(clk_i), .en_i(adv), .a_i(ev3_w), .b_i(xq_q[20]), .c_i(64'd0),
                  .p_o(ev4_w));
  tpl_fmul u_od4 (.clk_i(clk_i), .en_i(adv), .a_i(od3_w), .b_i(x_q[20]), .c_i(64'd0),
                  .p_o(od4_w));

  // stage 25: fraction sum and exponent term
  logic [63:0]            f_q;
  logic [EXP_BITS+63:0]   eln_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_q   <= sd_q[24].logv + ev4_w + od4_w;
      eln_q <= (EXP_BITS + 64)'(sd_q[24].ae) * (EXP_BITS + 64)'(LN2_Q64);
    end
  end

  // stage 26: total at 64 fraction bits
  logic [127:0] fw, t_q;
  assign fw = {{62{f_q[63]}}, f_q, 2'b00};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q <= sd_q[25].eneg ? fw - 128'(eln_q) : fw + 128'(eln_q);
    end
  end

  // stage 27: magnitude for base-10 scaling
  logic [127:0] tn_q;
  logic [127:0] tc_q [27:30];
  logic         ng_q [27:30];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tn_q     <= t_q[127] ? 128'd0 - t_q : t_q;
      tc_q[27] <= t_q;
      ng_q[27] <= t_q[127];
      for (int k = 28; k <= 30; k++) begin
        tc_q[k] <= tc_q[k-1];
        ng_q[k] <= ng_q[k-1];
      end
    end
  end

  // stages 28-29: magnitude times log10(e)
  logic [127:0] hi_w, lo_w;
  tpl_umul u_mul_hi (
    .clk_i(clk_i), .en_i(adv), .a_i(tn_q[127:64]), .b_i(LOG10E_Q64), .p_o(hi_w)
  );
  tpl_umul u_mul_lo (
    .clk_i(clk_i), .en_i(adv), .a_i(tn_q[63:0]), .b_i(LOG10E_Q64), .p_o(lo_w)
  );

  // stages 30-31: combine, restore sign, pick base
  logic [127:0] s_q, v_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= hi_w + {64'd0, lo_w[127:64]};
      v_q <= base_mode_q ? (ng_q[30] ? 128'd0 - s_q : s_q) : tc_q[30];
    end
  end

  // output register: round half up
  logic [127:0] rnd;
  assign rnd = v_q + (128'd1 << (RND_SH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= sd_q[LAST].special;
      out_value_q  <= sd_q[LAST].special ? RES_MIN : rnd[RND_SH +: 64];
    end
  end

  assign out_valid_o = out_vld_q;
  assign log_value_o = out_value_q;
  assign status_o    = out_status_q;

  // checks
  a_status_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> log_value_o == RES_MIN)
    else $error("status set without most negative value");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("held item lost from output register");

endmodule

/* dv/table_polynomial_natural_log_tb.sv */
// Testbench for the table-driven logarithm: bit-exact prediction, APB setup, random flow control.
`timescale 1ns / 1ps
module table_polynomial_natural_log_tb;
  import tpl_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 48;
  localparam logic [2:0] ADDR_BASE_MODE = 3'd0;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [63:0] x_bits_i;
  logic        out_valid_o, out_ready_i;
  logic [63:0] log_value_o;
  logic        status_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  table_polynomial_natural_log dut (.*);

  // Predictor state
  logic [63:0] ln_tab[ROM_DEPTH];
  logic [63:0] rcp_tab[ROM_DEPTH];
  logic        base10;

  // Pending results, oldest first
  logic [63:0] pend_value[$];
  logic        pend_status[$];

  int err_cnt;
  int cyc;
  int idle_pct;
  int stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Q62 signed multiply on magnitudes, truncated
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0]  ma, mb, m;
    logic [127:0] p;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p  = {64'd0, ma} * {64'd0, mb};
    m  = p[125:62];
    return (a[63] ^ b[63]) ? -m : m;
  endfunction

  task automatic build_tables();
    logic [127:0] p, num;
    logic [63:0]  u, u2, pw, sum, k, den, q, r;
    for (int n = 0; n < ROM_DEPTH - 1; n++) begin
      den = 64'(2 * ROM_DEPTH + n);
      num = 128'(n) << 63;
      u   = 64'(num / {64'd0, den});
      p   = {64'd0, u} * {64'd0, u};
      u2  = p[126:63];
      pw  = u;
      sum = '0;
      k   = 64'd1;
      while (pw != 0 && k < 400) begin
        sum = sum + pw / k;
        p   = {64'd0, pw} * {64'd0, u2};
        pw  = p[126:63];
        k   = k + 2;
      end
      ln_tab[n] = sum;
      den = 64'(ROM_DEPTH + n);
      num = 128'(ROM_DEPTH) << 62;
      q   = 64'(num / {64'd0, den});
      r   = 64'(num % {64'd0, den});
      if ({r, 1'b0} >= {1'b0, den}) q = q + 1;
      rcp_tab[n] = q;
    end
    ln_tab[ROM_DEPTH-1]  = LN2_Q62;
    rcp_tab[ROM_DEPTH-1] = 64'd1 << 61;
  endtask

  // Expected log value and status of one operand
  task automatic predict_log(input logic [63:0] xb, output logic [63:0] val,
                             output logic st);
    logic [51:0]  mant;
    logic [10:0]  ef;
    logic [7:0]   n;
    logic [63:0]  x, xq, ev, od, f, ae;
    logic [127:0] p, t, a;
    logic         nan, neg;
    int           e;
    mant = xb[51:0];
    ef   = xb[62:52];
    nan  = (ef == '1) && (mant != 0);
    if ((mant == 0 && ef == 0) || (xb[63] && !nan)) begin
      val = RES_MIN;
      st  = 1'b1;
      return;
    end
    n = mant[51:44];
    p = {84'd0, mant[43:0]} * {64'd0, rcp_tab[n]};
    x = p[115:52];
    if (n == 8'hFF) x = x - LAST_CORR;
    xq = qmul(x, x);
    ev = qmul(K8, xq) + K6;
    ev = qmul(ev, xq) + K4;
    ev = qmul(ev, xq) + K2;
    ev = qmul(ev, xq);
    od = qmul(K7, xq) + K5;
    od = qmul(od, xq) + K3;
    od = qmul(od, xq) + K1;
    od = qmul(od, x);
    f  = ln_tab[n] + ev + od;
    e  = int'(ef) - EXP_BIAS;
    ae = 64'(e < 0 ? -e : e);
    t  = {64'd0, ae} * {64'd0, LN2_Q64};
    if (e < 0) t = -t;
    t = t + ({{64{f[63]}}, f} << 2);
    // base-10 scaling on the magnitude
    if (base10) begin
      neg = t[127];
      if (neg) t = -t;
      a = {64'd0, t[127:64]} * {64'd0, LOG10E_Q64};
      p = {64'd0, t[63:0]} * {64'd0, LOG10E_Q64};
      a = a + {64'd0, p[127:64]};
      t = neg ? -a : a;
    end
    t   = t + (128'd1 << (63 - OUT_FRAC_BITS));
    val = t[64 + 63 - OUT_FRAC_BITS -: 64];
    st  = 1'b0;
  endtask

  // Cycle limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pend_value.size() == 0) begin
        $error("unexpected result value %h status %b", log_value_o, status_o);
        err_cnt++;
      end else begin
        if (log_value_o !== pend_value[0]) begin
          $error("log_value expected %h actual %h", pend_value[0], log_value_o);
          err_cnt++;
        end
        if (status_o !== pend_status[0]) begin
          $error("status expected %b actual %b", pend_status[0], status_o);
          err_cnt++;
        end
        void'(pend_value.pop_front());
        void'(pend_status.pop_front());
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(input logic [63:0] xb);
    logic [63:0] v;
    logic        s;
    in_valid_i <= 1'b1;
    x_bits_i   <= xb;
    do @(posedge clk_i); while (!in_ready_o);
    predict_log(xb, v, s);
    pend_value.push_back(v);
    pend_status.push_back(s);
    // each following cycle is idle with probability idle_pct
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pend_value.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_base_mode(input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BASE_MODE;
    pwdata  <= {31'd0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    base10 = mode;
  endtask

  // Mostly well-formed positive operands, plus specials and raw noise
  function automatic logic [63:0] rand_operand();
    logic [63:0] xb;
    xb = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        case ($urandom_range(0, 3))
          0: xb[62:0] = '0;
          1: xb[62:52] = '1;
          2: xb[62:52] = '0;
          default: xb[63] = 1'b1;
        endcase
      end
      2: begin
        xb[63] = 1'b0;
        xb[62:52] = 11'(EXP_BIAS + $urandom_range(0, 8) - 4);
        xb[51:44] = 8'hFF;
      end
      default: begin
        xb[63] = 1'b0;
        if (xb[62:52] == '0 || xb[62:52] == '1) xb[62:52] = 11'(EXP_BIAS);
        if ($urandom_range(0, 1)) xb[62:52] = 11'(EXP_BIAS + $urandom_range(0, 40) - 20);
      end
    endcase
    return xb;
  endfunction

  task automatic test_directed(input logic mode);
    logic [63:0] ops[18];
    ops = '{64'h0000000000000000, 64'h8000000000000000, 64'hBFF0000000000000,
            64'hFFF0000000000000, 64'h7FF0000000000000, 64'h7FF8000000000001,
            64'hFFF8000000000000, 64'h3FF0000000000000, 64'h4000000000000000,
            64'h3FE0000000000000, 64'h7FEFFFFFFFFFFFFF, 64'h0010000000000000,
            64'h0000000000000001, 64'h3FFFFFFFFFFFFFFF, 64'h3FFFF00000000000,
            64'h3FF8000000000000, 64'h4024000000000000, 64'h3FF00FFFFFFFFFFF};
    idle_pct  = 0;
    stall_pct = 0;
    write_base_mode(mode);
    foreach (ops[i]) send_item(ops[i]);
    wait_idle();
  endtask

  task automatic test_random(input logic mode, input int idle, input int stall,
                             input int count);
    idle_pct  = idle;
    stall_pct = stall;
    write_base_mode(mode);
    for (int i = 0; i < count; i++) begin
      send_item(rand_operand());
      // hold off once until the pipeline empties
      if (i == count / 2) begin
        in_valid_i <= 1'b0;
        while (pend_value.size() != 0) @(posedge clk_i);
      end
    end
    wait_idle();
  endtask

  initial begin
    err_cnt     = 0;
    cyc         = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    base10      = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    x_bits_i    <= '0;
    out_ready_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    build_tables();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed(1'b0);
    test_directed(1'b1);
    test_random(1'b0, 0, 0, 310);
    test_random(1'b1, 68, 0, 310);
    test_random(1'b0, 0, 68, 310);
    test_random(1'b1, 21, 21, 310);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
